// ===== rtl/mfrf_pkg.sv =====
// Shared types and constants for the mesh flood receive filter.
// Used by the top level; depends on nothing else.
`default_nettype none

package mfrf_pkg;

    // Default size of the recent (source, sequence) history.
    localparam int DEFAULT_HISTORY_DEPTH = 128;

    // Header field widths.
    localparam int LEN_W    = 8;
    localparam int NETID_W  = 16;
    localparam int PREFIX_W = 8;
    localparam int KIND_W   = 3;
    localparam int ADDR_W   = 16;
    localparam int SEQ_W    = 8;

    // Result field widths.
    localparam int VERDICT_W = 3;
    localparam int OFFSET_W  = 3;

    // Packed stream widths.
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 16;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // One history entry holds a source address and a sequence number.
    localparam int ENTRY_W = ADDR_W + SEQ_W;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_NETWORK_ID     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NETWORK_PREFIX = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_NODE_ADDRESS   = 2'd2;

    // Message kinds carried in the header.
    localparam logic [KIND_W-1:0] KIND_BROADCAST = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GROUP     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STATELESS = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STATEFUL  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ACK       = 3'd4;

    // Frames shorter than this are dropped.
    localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 8'd7;

    // Payload offsets for delivered frames.
    localparam logic [OFFSET_W-1:0] BCAST_OFFSET = 3'd4;
    localparam logic [OFFSET_W-1:0] UCAST_OFFSET = 3'd6;
    localparam logic [OFFSET_W-1:0] NO_OFFSET    = 3'd0;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_OK    = 3'd0,
        VERDICT_SHORT = 3'd1,
        VERDICT_NET   = 3'd2,
        VERDICT_DUP   = 3'd3,
        VERDICT_TYPE  = 3'd4
    } verdict_t;

endpackage

`default_nettype wire

// ===== rtl/mesh_flood_receive_filter.sv =====
// Top level of the mesh flood receive filter: header checks, duplicate scan, result register.
// Depends on mfrf_pkg and instantiates mfrf_ram for the history.
//
//  Channel   Direction  Ports                          Contents
//  s_        in         s_tvalid s_tready s_tdata      frame header, msg_kind in s_tuser
//  m_        out        m_tvalid m_tready m_tdata      verdict, deliver, offset, length, relay
//  cfg_      in         cfg_wr_en cfg_addr cfg_wdata   network_id, network_prefix, node_address
//
// A frame that fails the length or network check skips the scan and goes straight to the
// result state. Any other frame is compared against every filled history entry, one RAM read
// per cycle, before its result is registered.
// One request is processed at a time; the next is taken as soon as the result is parked in
// the output register, even if the consumer has not yet taken it.
// Reset clears the configuration, the write pointer and the fill count. The history RAM is not
// cleared: only entries below the fill count are ever compared, so no clearing pass is needed.
// A stalled output holds the sequencer in its result state until the slot frees up.
`default_nettype none

module mesh_flood_receive_filter #(
    parameter int HISTORY_DEPTH = mfrf_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [7:0] frame_length, [23:8] frame_net_id, [31:24] frame_net_prefix,
    // [47:32] source_addr, [55:48] seq_number, [71:56] dest_addr
    input  wire logic [mfrf_pkg::S_TDATA_W-1:0]    s_tdata,
    // [2:0] msg_kind
    input  wire logic [mfrf_pkg::KIND_W-1:0]       s_tuser,

    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [2:0] verdict, [3] deliver, [6:4] payload_offset, [14:7] payload_length, [15] relay
    output logic      [mfrf_pkg::M_TDATA_W-1:0]    m_tdata,

    input  wire logic                              cfg_wr_en,
    input  wire logic [mfrf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [mfrf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    // Address width of the history and width of a counter that can hold the depth itself.
    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [mfrf_pkg::NETID_W-1:0]  network_id_reg;
    logic [mfrf_pkg::PREFIX_W-1:0] network_prefix_reg;
    logic [mfrf_pkg::ADDR_W-1:0]   node_address_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            network_id_reg     <= '0;
            network_prefix_reg <= '0;
            node_address_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                mfrf_pkg::CFG_NETWORK_ID:     network_id_reg     <= cfg_wdata;
                mfrf_pkg::CFG_NETWORK_PREFIX: network_prefix_reg <= cfg_wdata[mfrf_pkg::PREFIX_W-1:0];
                mfrf_pkg::CFG_NODE_ADDRESS:   node_address_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input unpacking.
    // ------------------------------------------------------------------
    logic [mfrf_pkg::LEN_W-1:0]    in_len;
    logic [mfrf_pkg::NETID_W-1:0]  in_netid;
    logic [mfrf_pkg::PREFIX_W-1:0] in_prefix;
    logic [mfrf_pkg::ADDR_W-1:0]   in_src;
    logic [mfrf_pkg::SEQ_W-1:0]    in_seq;
    logic [mfrf_pkg::ADDR_W-1:0]   in_dst;

    assign in_len    = s_tdata[7:0];
    assign in_netid  = s_tdata[23:8];
    assign in_prefix = s_tdata[31:24];
    assign in_src    = s_tdata[47:32];
    assign in_seq    = s_tdata[55:48];
    assign in_dst    = s_tdata[71:56];

    // ------------------------------------------------------------------
    // Sequencer and request registers.
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [mfrf_pkg::LEN_W-1:0]   len_reg;
    logic [mfrf_pkg::KIND_W-1:0]  kind_reg;
    logic [mfrf_pkg::ADDR_W-1:0]  dst_reg;
    logic [mfrf_pkg::ENTRY_W-1:0] key_reg;
    logic                         short_reg;
    logic                         netbad_reg;

    logic [CW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic          hit_reg, hit_next;
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [CW-1:0] fill_reg, fill_next;

    logic                           m_valid_reg, m_valid_next;
    logic [mfrf_pkg::M_TDATA_W-1:0] m_data_reg;

    logic                           in_accept;
    logic                           issue;
    logic                           out_free;
    logic                           load_out;
    logic                           mem_we;
    logic [mfrf_pkg::ENTRY_W-1:0]   mem_rdata;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    // A history read goes out for every filled entry not yet visited.
    assign issue = (state_reg == ST_SCAN) && (idx_reg < fill_reg);

    // ------------------------------------------------------------------
    // Verdict and result fields, computed once the scan has finished.
    // ------------------------------------------------------------------
    mfrf_pkg::verdict_t             verdict;
    logic                           deliver;
    logic [mfrf_pkg::OFFSET_W-1:0]  offset;
    logic [mfrf_pkg::LEN_W-1:0]     pay_len;
    logic                           relay;

    always_comb begin
        verdict = mfrf_pkg::VERDICT_OK;
        deliver = 1'b0;
        offset  = mfrf_pkg::NO_OFFSET;
        priority if (short_reg) begin
            verdict = mfrf_pkg::VERDICT_SHORT;
        end else if (netbad_reg) begin
            verdict = mfrf_pkg::VERDICT_NET;
        end else if (hit_reg) begin
            verdict = mfrf_pkg::VERDICT_DUP;
        end else if (kind_reg == mfrf_pkg::KIND_BROADCAST) begin
            deliver = 1'b1;
            offset  = mfrf_pkg::BCAST_OFFSET;
        end else if (dst_reg == node_address_reg) begin
            // Addressed to this node: stateless and stateful are delivered, an ack
            // is only relayed, and anything else (group included) is an illegal type.
            if (kind_reg == mfrf_pkg::KIND_STATELESS || kind_reg == mfrf_pkg::KIND_STATEFUL) begin
                deliver = 1'b1;
                offset  = mfrf_pkg::UCAST_OFFSET;
            end else if (kind_reg != mfrf_pkg::KIND_ACK) begin
                verdict = mfrf_pkg::VERDICT_TYPE;
            end
        end else begin
            // A frame for another node is relayed but not delivered.
        end
        relay   = (verdict == mfrf_pkg::VERDICT_OK);
        pay_len = deliver ? (len_reg - {{(mfrf_pkg::LEN_W-mfrf_pkg::OFFSET_W){1'b0}}, offset})
                          : '0;
    end

    assign load_out = (state_reg == ST_RESULT) && out_free;
    assign mem_we   = load_out && relay;

    // ------------------------------------------------------------------
    // Next-state logic.
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        pend_next    = 1'b0;
        hit_next     = hit_reg;
        wptr_next    = wptr_reg;
        fill_next    = fill_reg;
        m_valid_next = m_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    idx_next = '0;
                    hit_next = 1'b0;
                    // The length and network checks need no history, so a frame that
                    // fails one of them skips the scan.
                    if (in_len < mfrf_pkg::MIN_FRAME_LEN || in_netid != network_id_reg
                            || in_prefix != network_prefix_reg) begin
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                pend_next = issue;
                if (issue) begin
                    idx_next = idx_reg + CW'(1);
                end
                // Read data of the previous cycle is compared here.
                if (pend_reg && mem_rdata == key_reg) begin
                    hit_next = 1'b1;
                end
                if (!issue && !pend_reg) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (relay) begin
                        wptr_next = (wptr_reg == AW'(HISTORY_DEPTH - 1)) ? '0
                                                                         : wptr_reg + AW'(1);
                        if (fill_reg != CW'(HISTORY_DEPTH)) begin
                            fill_next = fill_reg + CW'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            wptr_reg    <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            hit_reg     <= hit_next;
            wptr_reg    <= wptr_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Request payload and precomputed check flags.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            len_reg    <= in_len;
            kind_reg   <= s_tuser;
            dst_reg    <= in_dst;
            key_reg    <= {in_src, in_seq};
            short_reg  <= (in_len < mfrf_pkg::MIN_FRAME_LEN);
            netbad_reg <= (in_netid != network_id_reg) || (in_prefix != network_prefix_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= {relay, pay_len, offset, deliver, verdict};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // History of recently seen (source, sequence) pairs. Writes happen only in the
    // result state and reads only while scanning, so the two never touch one entry
    // in overlapping cycles.
    // ------------------------------------------------------------------
    mfrf_ram #(
        .WIDTH (mfrf_pkg::ENTRY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (wptr_reg),
        .wr_data (key_reg),
        .rd_en   (issue),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (mem_rdata)
    );

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(HISTORY_DEPTH))
        else $error("history fill count exceeds its depth");

    a_scan_index_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> idx_reg <= fill_reg)
        else $error("scan index ran past the filled entries");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> state_reg != ST_IDLE && !s_tready)
        else $error("accepted request did not start processing");

    a_write_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> m_tvalid && m_tdata[15] && fill_reg != '0)
        else $error("history write without a relayed result");

    a_no_read_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && issue))
        else $error("history read and write in the same cycle");

endmodule

`default_nettype wire

// ===== rtl/mfrf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Self-contained; no package needed.
`default_nettype none

module mfrf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for mesh_flood_receive_filter: directed header cases, a ring
// overflow run and random flooding traffic, all checked against a predictor in this file.
// Depends on mfrf_pkg and the RTL top level; reads no files.
`timescale 1ns / 100ps

module tb_top;
    import mfrf_pkg::*;

    localparam int HIST_DEPTH  = DEFAULT_HISTORY_DEPTH;
    // Cycles without any accepted request, delivered result or register write before the run
    // is abandoned. The slowest frame scans the full history and may then sit behind a stalled
    // consumer, so this leaves a wide margin.
    localparam int STALL_LIMIT = 2000;

    // Kinds 5 to 7 have no meaning on the air; the filter rejects them when aimed at this node.
    localparam logic [KIND_W-1:0] KIND_RSVD_5 = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RSVD_7 = 3'd7;

    // One received header. Below the kind, the members line up with the s_tdata layout,
    // so the low S_TDATA_W bits of the struct can be driven as they are.
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [ADDR_W-1:0]   dest;
        logic [SEQ_W-1:0]    seq;
        logic [ADDR_W-1:0]   src;
        logic [PREFIX_W-1:0] prefix;
        logic [NETID_W-1:0]  net_id;
        logic [LEN_W-1:0]    length;
    } frame_t;

    // One filter decision, laid out as m_tdata.
    typedef struct packed {
        logic                relay;
        logic [LEN_W-1:0]    plen;
        logic [OFFSET_W-1:0] offset;
        logic                deliver;
        verdict_t            verdict;
    } decision_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [KIND_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor state: our own copy of the registers and of the duplicate ring.
    logic [NETID_W-1:0]  cfg_net_id = '0;
    logic [PREFIX_W-1:0] cfg_prefix = '0;
    logic [ADDR_W-1:0]   cfg_node   = '0;
    logic [ADDR_W-1:0]   hist_src [HIST_DEPTH];
    logic [SEQ_W-1:0]    hist_seq [HIST_DEPTH];
    bit                  hist_valid [HIST_DEPTH];
    int                  hist_wr_ptr = 0;

    // Decisions predicted for accepted headers, oldest first.
    decision_t pending_verdicts [$];
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    // Random stalls on both sides; switched off for the last part of the run.
    bit        idle_on        = 1'b1;
    int        stall_left     = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    mesh_flood_receive_filter #(
        .HISTORY_DEPTH (HIST_DEPTH)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        // [7:0] frame_length, [23:8] frame_net_id, [31:24] frame_net_prefix,
        // [47:32] source_addr, [55:48] seq_number, [71:56] dest_addr
        .s_tdata   (s_tdata),
        // [2:0] msg_kind
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        // [2:0] verdict, [3] deliver, [6:4] payload_offset, [14:7] payload_length, [15] relay
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Works out what the filter must decide for one header and updates the ring the same
    // way the block does: only a frame that passes every check is recorded.
    function automatic decision_t filter_frame(input frame_t f);
        decision_t r;
        bit        seen;
        seen      = 1'b0;
        r.verdict = VERDICT_OK;
        r.deliver = 1'b0;
        r.offset  = NO_OFFSET;
        r.plen    = '0;
        r.relay   = 1'b0;
        if (f.length < MIN_FRAME_LEN) begin
            r.verdict = VERDICT_SHORT;
        end else if (f.net_id != cfg_net_id || f.prefix != cfg_prefix) begin
            r.verdict = VERDICT_NET;
        end else begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                if (hist_valid[k] && hist_src[k] == f.src && hist_seq[k] == f.seq) begin
                    seen = 1'b1;
                end
            end
            if (seen) begin
                r.verdict = VERDICT_DUP;
            end else if (f.kind == KIND_BROADCAST) begin
                // A broadcast is delivered no matter what the destination says.
                r.deliver = 1'b1;
                r.offset  = BCAST_OFFSET;
            end else if (f.dest == cfg_node) begin
                if (f.kind == KIND_STATELESS || f.kind == KIND_STATEFUL) begin
                    r.deliver = 1'b1;
                    r.offset  = UCAST_OFFSET;
                end else if (f.kind != KIND_ACK) begin
                    // Group membership is never claimed, so a group frame aimed at our
                    // own address is as unusable as an undefined kind.
                    r.verdict = VERDICT_TYPE;
                end
            end
        end
        if (r.verdict == VERDICT_OK) begin
            r.relay                = 1'b1;
            hist_src[hist_wr_ptr]   = f.src;
            hist_seq[hist_wr_ptr]   = f.seq;
            hist_valid[hist_wr_ptr] = 1'b1;
            hist_wr_ptr             = (hist_wr_ptr + 1) % HIST_DEPTH;
        end
        if (r.deliver) begin
            r.plen = f.length - {{(LEN_W - OFFSET_W){1'b0}}, r.offset};
        end
        return r;
    endfunction

    // Header on the current network with the given content.
    function automatic frame_t make_frame(input logic [LEN_W-1:0] length,
                                          input logic [KIND_W-1:0] kind,
                                          input logic [ADDR_W-1:0] src,
                                          input logic [SEQ_W-1:0] seq,
                                          input logic [ADDR_W-1:0] dest);
        frame_t f;
        f.kind   = kind;
        f.dest   = dest;
        f.seq    = seq;
        f.src    = src;
        f.prefix = cfg_prefix;
        f.net_id = cfg_net_id;
        f.length = length;
        return f;
    endfunction

    // Offers one header request and records the predicted decision once it is taken.
    // Valid is only lowered ahead of a gap, so back-to-back requests keep it high.
    task automatic send_frame(input frame_t f);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tdata  <= f[S_TDATA_W-1:0];
        s_tuser  <= f.kind;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_verdicts.push_back(filter_frame(f));
    endtask

    // Stops offering requests, waits for every predicted decision to arrive, then lets
    // a few more cycles pass so that a stray extra result would still be caught.
    task automatic settle(input int extra_cycles);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (extra_cycles) @(posedge aclk);
    endtask

    // Writes all three registers back to back; only called while the filter is idle.
    task automatic load_config(input logic [NETID_W-1:0] net_id,
                               input logic [PREFIX_W-1:0] prefix,
                               input logic [ADDR_W-1:0] node);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_NETWORK_ID;
        cfg_wdata <= net_id;
        @(posedge aclk);
        cfg_addr  <= CFG_NETWORK_PREFIX;
        cfg_wdata <= {{(CFG_DATA_W - PREFIX_W){1'b0}}, prefix};
        @(posedge aclk);
        cfg_addr  <= CFG_NODE_ADDRESS;
        cfg_wdata <= node;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_net_id = net_id;
        cfg_prefix = prefix;
        cfg_node   = node;
    endtask

    // Length limits: the shortest lengths are dropped before the network check, seven
    // bytes is the first usable length, and the longest frame keeps its full payload.
    task automatic test_length_limits();
        frame_t f;
        f = make_frame(8'd0, KIND_BROADCAST, 16'h0001, 8'h00, 16'hFFFF);
        f.net_id = ~cfg_net_id;
        send_frame(f);
        send_frame(make_frame(8'd6, KIND_BROADCAST, 16'h0002, 8'h00, 16'h0000));
        send_frame(make_frame(8'd7, KIND_BROADCAST, 16'h0003, 8'h00, 16'h0000));
        send_frame(make_frame(8'd255, KIND_BROADCAST, 16'h0004, 8'hFF, 16'h0000));
        send_frame(make_frame(8'd7, KIND_STATELESS, 16'h0005, 8'h80, cfg_node));
    endtask

    // Network check: one wrong bit in either field is enough, and it wins over a pair
    // that is already in the ring.
    task automatic test_network_match();
        frame_t f;
        f = make_frame(8'd20, KIND_BROADCAST, 16'h0010, 8'h01, 16'h0000);
        f.net_id = cfg_net_id ^ 16'h8000;
        send_frame(f);
        f = make_frame(8'd20, KIND_BROADCAST, 16'h0011, 8'h01, 16'h0000);
        f.prefix = cfg_prefix ^ 8'h01;
        send_frame(f);
        f = make_frame(8'd20, KIND_STATEFUL, 16'h0012, 8'h01, cfg_node);
        f.net_id = ~cfg_net_id;
        f.prefix = ~cfg_prefix;
        send_frame(f);
        f = make_frame(8'd20, KIND_BROADCAST, 16'h0003, 8'h00, 16'h0000);
        f.prefix = cfg_prefix ^ 8'h40;
        send_frame(f);
    endtask

    // Every kind addressed to this node, then group, stateless, ack and kind 5 addressed to
    // some other node.
    task automatic test_message_kinds();
        logic [KIND_W-1:0] others [4];
        others = '{KIND_GROUP, KIND_STATELESS, KIND_ACK, KIND_RSVD_5};
        for (int k = 0; k <= KIND_RSVD_7; k++) begin
            send_frame(make_frame(8'd40, KIND_W'(k), ADDR_W'(16'h0100 + k), 8'h5A, cfg_node));
        end
        for (int k = 0; k < 4; k++) begin
            send_frame(make_frame(8'd40, others[k], ADDR_W'(16'h0200 + k), 8'hA5,
                                  cfg_node ^ 16'h0001));
        end
    endtask

    // Duplicate handling: a recorded pair is dropped whatever its kind, a dropped frame
    // leaves no trace in the ring, and a short copy of a known pair is reported as short.
    task automatic test_duplicate_pairs();
        send_frame(make_frame(8'd30, KIND_STATEFUL, 16'h0003, 8'h00, cfg_node));
        send_frame(make_frame(8'd30, KIND_STATELESS, 16'h0101, 8'h5A, cfg_node));
        send_frame(make_frame(8'd30, KIND_ACK, 16'h0101, 8'h5A, cfg_node));
        send_frame(make_frame(8'd3, KIND_BROADCAST, 16'h0004, 8'hFF, 16'h0000));
    endtask

    // Fills the ring past its depth with fresh pairs, then replays the oldest pairs: the
    // overwritten one is accepted again, the next one is still a duplicate.
    task automatic test_ring_wrap();
        logic [SEQ_W-1:0]  seqs [HIST_DEPTH + 1];
        logic [KIND_W-1:0] good_kinds [4];
        good_kinds = '{KIND_BROADCAST, KIND_STATELESS, KIND_STATEFUL, KIND_ACK};
        for (int i = 0; i <= HIST_DEPTH; i++) begin
            seqs[i] = SEQ_W'($urandom);
            send_frame(make_frame(LEN_W'($urandom_range(7, 255)), good_kinds[$urandom_range(0, 3)],
                                  ADDR_W'(16'hC000 + i), seqs[i], ADDR_W'($urandom)));
        end
        send_frame(make_frame(8'd64, KIND_BROADCAST, 16'hC000, seqs[0], 16'h0000));
        send_frame(make_frame(8'd64, KIND_BROADCAST, 16'hC002, seqs[2], 16'h0000));
        send_frame(make_frame(8'd64, KIND_BROADCAST, 16'hC001, seqs[1], 16'h0000));
    endtask

    // Random traffic. Most frames are well formed, drawn from a small set of sources and
    // sequence numbers so that duplicates and ring overwrites are common; the rest are
    // noise, either wholly random or off the network by a single bit.
    task automatic test_random_traffic(input int count);
        logic [ADDR_W-1:0] src_pool [8];
        frame_t            f;
        src_pool[0] = 16'h0000;
        src_pool[1] = 16'hFFFF;
        for (int i = 2; i < 8; i++) src_pool[i] = ADDR_W'($urandom);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 8) begin
                f = make_frame(($urandom_range(0, 15) == 0) ? LEN_W'($urandom_range(0, 6))
                                                            : LEN_W'($urandom_range(7, 255)),
                               KIND_W'($urandom_range(0, 7)),
                               src_pool[$urandom_range(0, 7)],
                               $urandom_range(0, 1) ? SEQ_W'($urandom_range(0, 15))
                                                    : SEQ_W'($urandom),
                               $urandom_range(0, 1) ? cfg_node : ADDR_W'($urandom));
            end else begin
                f.kind   = KIND_W'($urandom);
                f.dest   = ADDR_W'($urandom);
                f.seq    = SEQ_W'($urandom);
                f.src    = ADDR_W'($urandom);
                f.length = LEN_W'($urandom);
                if ($urandom_range(0, 1) == 0) begin
                    f.prefix = PREFIX_W'($urandom);
                    f.net_id = NETID_W'($urandom);
                end else begin
                    f.prefix = cfg_prefix;
                    f.net_id = cfg_net_id;
                    if ($urandom_range(0, 1) == 0) begin
                        f.net_id[$urandom_range(0, NETID_W - 1)] ^= 1'b1;
                    end else begin
                        f.prefix[$urandom_range(0, PREFIX_W - 1)] ^= 1'b1;
                    end
                end
            end
            send_frame(f);
        end
    endtask

    // Consumer side: ready drops for random bursts while stalls are enabled.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Every decision the filter hands over is matched against the oldest prediction.
    always @(posedge aclk) begin : result_check
        decision_t got;
        decision_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = decision_t'(m_tdata);
            if (pending_verdicts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: unexpected result 0x%04h with nothing outstanding",
                             $realtime, m_tdata);
                end
            end else begin
                want = pending_verdicts.pop_front();
                if (got.verdict !== want.verdict || got.deliver !== want.deliver ||
                    got.offset !== want.offset || got.plen !== want.plen ||
                    got.relay !== want.relay) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: expected verdict=%0d deliver=%0d offset=%0d len=%0d relay=%0d",
                                 $realtime, want.verdict, want.deliver, want.offset,
                                 want.plen, want.relay);
                        $display("%0t:   actual verdict=%0d deliver=%0d offset=%0d len=%0d relay=%0d",
                                 $realtime, got.verdict, got.deliver, got.offset,
                                 got.plen, got.relay);
                    end
                end
            end
        end
    end

    // Watchdog: too long without a handshake on any port or a register write means a hang.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        load_config(16'hA5C3, 8'h3C, 16'h1234);
        test_length_limits();
        test_network_match();
        test_message_kinds();
        test_duplicate_pairs();

        // All-zero registers make address zero this node's own.
        settle(4);
        load_config(16'h0000, 8'h00, 16'h0000);
        test_ring_wrap();

        settle(4);
        load_config(16'hFFFF, 8'hFF, 16'hFFFF);
        test_random_traffic(240);

        settle(4);
        load_config(NETID_W'($urandom), PREFIX_W'($urandom), ADDR_W'($urandom));
        test_random_traffic(240);

        // Last stretch runs at full rate on both sides.
        settle(4);
        idle_on <= 1'b0;
        load_config(NETID_W'($urandom), PREFIX_W'($urandom), ADDR_W'($urandom));
        test_random_traffic(240);

        settle(HIST_DEPTH + 8);
        if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
